>>> src/scpa_pkg.sv
package scpa_pkg;

	localparam int ANGLE_W         = 24;
	localparam int OUT_W           = 16;
	localparam int ANGLE_FRAC_BITS = 16;
	localparam int OUT_FRAC_BITS   = 15;

	// internal fixed point: unsigned, 30 fraction bits
	localparam int QB  = 30;
	localparam int M_W = 31;

	// shifted angle magnitude and number of quotient bits of angle / (pi/2)
	localparam int A_W   = ANGLE_W + QB - ANGLE_FRAC_BITS;
	localparam int QUO_W = A_W - QB;

	localparam logic [M_W-1:0] HALF_PI_Q = 31'd1686629713;
	localparam logic [23:0]    C5_Q      = 24'd8619999;
	localparam logic [27:0]    C3_MAG_Q  = 28'd178892904;

	localparam int QUEUE_DEPTH_DEF = 4;

	typedef struct packed {
		logic           sneg;
		logic           cneg;
		logic [M_W-1:0] ms;
		logic [M_W-1:0] mc;
	} fold_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

>>> src/scpa_if.sv
interface scpa_in_if;
	import scpa_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [ANGLE_W-1:0] angle;

	modport source (output valid, output angle, input ready);
	modport sink (input valid, input angle, output ready);
endinterface

interface scpa_out_if;
	import scpa_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] sin_value;
	logic signed [OUT_W-1:0] cos_value;

	modport source (output valid, output sin_value, output cos_value, input ready);
	modport sink (input valid, input sin_value, input cos_value, output ready);
endinterface

>>> src/scpa_front.sv
module scpa_front (
	input  logic            clk,
	input  logic            arst_n,
	scpa_in_if.sink         angle_ch,
	output logic            push,
	output scpa_pkg::fold_t push_data,
	input  logic            full
);
	import scpa_pkg::*;

	logic                 adv;
	logic [ANGLE_W-1:0]   raw;
	logic [ANGLE_W-1:0]   mag;
	logic                 v_s    [0:QUO_W];
	logic                 neg_s  [0:QUO_W];
	logic [1:0]           quad_s [0:QUO_W];
	logic [A_W-1:0]       rem_s  [0:QUO_W];
	logic [M_W-1:0]       m;
	logic [M_W-1:0]       m_mirror;
	logic [1:0]           q;

	// hold the whole front while its last word waits for queue space
	assign adv            = !v_s[QUO_W] || !full;
	assign angle_ch.ready = adv;

	assign raw = angle_ch.angle;
	assign mag = raw[ANGLE_W-1] ? (~raw + 1'b1) : raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (adv) begin
			v_s[0] <= angle_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s[0]  <= raw[ANGLE_W-1];
			quad_s[0] <= 2'b00;
			rem_s[0]  <= A_W'(mag) << (QB - ANGLE_FRAC_BITS);
		end
	end

	// restoring reduction by pi/2, one quotient bit per stage; 2pi is exactly
	// four times pi/2, so the low two quotient bits are the quadrant
	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		localparam int             J   = QUO_W - 1 - k;
		localparam logic [A_W-1:0] DIV = A_W'(HALF_PI_Q) << J;

		logic       ge;
		logic [1:0] qn;

		assign ge = rem_s[k] >= DIV;
		assign qn = ge ? (quad_s[k] | 2'(1 << J)) : quad_s[k];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (adv) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				neg_s[k+1]  <= neg_s[k];
				quad_s[k+1] <= qn;
				rem_s[k+1]  <= ge ? (rem_s[k] - DIV) : rem_s[k];
			end
		end
	end

	// fold: mirror sine in odd quadrants, cosine in even ones
	assign m        = rem_s[QUO_W][M_W-1:0];
	assign q        = quad_s[QUO_W];
	assign m_mirror = HALF_PI_Q - m;

	assign push           = v_s[QUO_W] && !full;
	assign push_data.ms   = q[0] ? m_mirror : m;
	assign push_data.mc   = q[0] ? m : m_mirror;
	assign push_data.sneg = neg_s[QUO_W] ^ q[1];
	assign push_data.cneg = q[1] ^ q[0];

endmodule

>>> src/scpa_queue.sv
module scpa_queue #(
	parameter int DEPTH = scpa_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  scpa_pkg::fold_t   push_data,
	input  logic              pop,
	output scpa_pkg::fold_t   head,
	output scpa_pkg::q_stat_t stat
);
	import scpa_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	fold_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = cnt_q == CNT_W'(DEPTH);
	assign stat.empty = cnt_q == '0;

endmodule

>>> src/scpa_back.sv
module scpa_back (
	input  logic              clk,
	input  logic              arst_n,
	input  scpa_pkg::fold_t   head,
	input  scpa_pkg::q_stat_t stat,
	output logic              pop,
	scpa_out_if.source        trig_ch
);
	import scpa_pkg::*;

	logic                  adv;
	logic                  v_s1, v_s2, v_s3, v_s4, v_s5, v_q;
	logic [M_W-1:0]        m_in   [2];
	logic                  neg_in [2];
	logic                  neg_s1 [2];
	logic                  neg_s2 [2];
	logic                  neg_s3 [2];
	logic                  neg_s4 [2];
	logic                  neg_s5 [2];
	logic [M_W-1:0]        m_s1   [2];
	logic [M_W-1:0]        m_s2   [2];
	logic [M_W-1:0]        m_s3   [2];
	logic [M_W-1:0]        m_s4   [2];
	logic [31:0]           x2_s1  [2];
	logic [24:0]           c5x_s2 [2];
	logic [31:0]           cube_s2 [2];
	logic [31:0]           cube_s3 [2];
	logic [27:0]           coef_s3 [2];
	logic [29:0]           corr_s4 [2];
	logic [M_W-1:0]        res_s5 [2];
	logic signed [OUT_W-1:0] val_q [2];

	function automatic logic signed [OUT_W-1:0] saturate(input logic [M_W-1:0] v,
			input logic neg);
		logic [31:0] r;
		logic [31:0] nr;
		logic [31:0] hi;
		r  = 32'(v) >> (QB - OUT_FRAC_BITS);
		nr = -r;
		hi = 32'((1 << (OUT_W - 1)) - 1);
		if (neg) begin
			if (r > hi + 32'd1) begin
				return {1'b1, {(OUT_W-1){1'b0}}};
			end
			return nr[OUT_W-1:0];
		end
		if (r > hi) begin
			return {1'b0, {(OUT_W-1){1'b1}}};
		end
		return r[OUT_W-1:0];
	endfunction

	// stall everything behind a result that is not taken
	assign adv = !v_q || trig_ch.ready;
	assign pop = adv && !stat.empty;

	assign m_in[0]   = head.ms;
	assign m_in[1]   = head.mc;
	assign neg_in[0] = head.sneg;
	assign neg_in[1] = head.cneg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_q  <= 1'b0;
		end else if (adv) begin
			v_s1 <= !stat.empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_q  <= v_s5;
		end
	end

	// one lane for sine, one for cosine: m - (C3 - C5*m^2)*m^3
	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic [61:0] sq;
		logic [54:0] c5p;
		logic [61:0] cbp;
		logic [59:0] crp;

		assign sq  = 62'(m_in[l]) * 62'(m_in[l]);
		assign c5p = 55'(C5_Q) * 55'(x2_s1[l]);
		assign cbp = 62'(x2_s1[l]) * 62'(m_s1[l]);
		assign crp = 60'(coef_s3[l]) * 60'(cube_s3[l]);

		always_ff @(posedge clk) begin
			if (adv) begin
				neg_s1[l]  <= neg_in[l];
				m_s1[l]    <= m_in[l];
				x2_s1[l]   <= sq[61:30];

				neg_s2[l]  <= neg_s1[l];
				m_s2[l]    <= m_s1[l];
				c5x_s2[l]  <= c5p[54:30];
				cube_s2[l] <= cbp[61:30];

				neg_s3[l]  <= neg_s2[l];
				m_s3[l]    <= m_s2[l];
				cube_s3[l] <= cube_s2[l];
				coef_s3[l] <= C3_MAG_Q - 28'(c5x_s2[l]);

				neg_s4[l]  <= neg_s3[l];
				m_s4[l]    <= m_s3[l];
				corr_s4[l] <= crp[59:30];

				neg_s5[l]  <= neg_s4[l];
				res_s5[l]  <= (M_W'(corr_s4[l]) > m_s4[l]) ? '0
					: m_s4[l] - M_W'(corr_s4[l]);

				val_q[l]   <= saturate(res_s5[l], neg_s5[l]);
			end
		end
	end

	assign trig_ch.valid     = v_q;
	assign trig_ch.sin_value = val_q[0];
	assign trig_ch.cos_value = val_q[1];

endmodule

>>> src/sine_cosine_poly_approx_unit.sv
// Sine and cosine of a Q7.16 angle, Q1.15 results.
// Throughput: one angle per cycle when nothing stalls; the front reduces by pi/2
// in 8 pipelined compare-subtract stages, the back in 5 polynomial stages plus
// an output register. A queue of 4 words by default lets either side stall alone.
// Reset clears valid flags, queue pointers and queue count only; no clearing pass.
module sine_cosine_poly_approx_unit #(
	parameter int QUEUE_DEPTH = scpa_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	scpa_in_if.sink    angle_ch,
	scpa_out_if.source trig_ch
);
	import scpa_pkg::*;

	logic    q_push;
	logic    q_pop;
	fold_t   q_wdata;
	fold_t   q_head;
	q_stat_t q_stat;

	scpa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.angle_ch  (angle_ch),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_stat.full)
	);

	scpa_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.pop       (q_pop),
		.head      (q_head),
		.stat      (q_stat)
	);

	scpa_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (q_head),
		.stat    (q_stat),
		.pop     (q_pop),
		.trig_ch (trig_ch)
	);

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("queue written while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("queue read while empty");

	a_fill_by_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(q_stat.full) |-> $past(q_push && !q_pop))
		else $error("queue became full without a write");
`endif

endmodule
